// File: sv/mvo_pkg.sv
package mvo_pkg;

  localparam int SAMPLE_RATE_HZ   = 48000;
  localparam int SINE_TABLE_DEPTH = 1024;
  localparam int SINE_IDX_W       = $clog2(SINE_TABLE_DEPTH);
  localparam int SINE_Q_W         = SINE_IDX_W - 2;
  localparam int SINE_QUARTER     = SINE_TABLE_DEPTH / 4;

  localparam int PHASE_W    = 32;
  localparam int SAMPLE_W   = 16;
  localparam int LEVEL_W    = 16;
  localparam int RF_W       = 16;
  localparam int NOTE_W     = 7;
  localparam int VEL_W      = 7;
  localparam int NOTE_COUNT = 128;
  localparam int APB_ADDR_W = 2;

  localparam int LEVEL_SCALE = 98304;
  localparam int LEVEL_ROUND = 635;
  localparam int LEVEL_DIV   = 1270;

  localparam logic [RF_W-1:0]     RF_ONE   = 16'd32768;
  localparam logic [14:0]         RF_DECAY = 15'd32440;
  localparam logic [RF_W-1:0]     RF_STOP  = 16'd163;
  localparam logic [SAMPLE_W-1:0] WAVE_MAX = 16'h7fff;
  // -32767 in two's complement
  localparam logic [SAMPLE_W-1:0] WAVE_MIN = 16'h8001;

  localparam logic [APB_ADDR_W-1:0] ADDR_WAVE_SHAPE = 2'd0;

  typedef enum logic [1:0] {
    CMD_TICK      = 2'd0,
    CMD_NOTE_ON   = 2'd1,
    CMD_NOTE_OFF  = 2'd2,
    CMD_NOTE_KILL = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    WAVE_SINE     = 2'd0,
    WAVE_SQUARE   = 2'd1,
    WAVE_SAW      = 2'd2,
    WAVE_TRIANGLE = 2'd3
  } wave_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WAVE,
    ST_LEVEL,
    ST_RELEASE
  } state_t;

  typedef struct packed {
    logic note_on;
    logic note_off;
    logic note_kill;
    logic wave_load;
    logic level_load;
    logic emit;
  } dp_cmd_t;

  typedef struct packed {
    logic out_free;
  } dp_status_t;

  typedef logic [PHASE_W-1:0]  step_table_t  [NOTE_COUNT];
  typedef logic [LEVEL_W-1:0]  level_table_t [NOTE_COUNT];
  typedef logic [SAMPLE_W-1:0] sine_table_t  [SINE_QUARTER];

  localparam logic [31:0] SEMITONE_FREQ_Q24 [12] = '{
    32'd137167145, 32'd145323527, 32'd153964914, 32'd163120145,
    32'd172819773, 32'd183096171, 32'd193983637, 32'd205518504,
    32'd217739270, 32'd230686720, 32'd244404066, 32'd258937088
  };

  function automatic step_table_t build_step_table();
    step_table_t tbl;
    logic [63:0] f;
    int n;
    for (int oct = 0; oct < 11; oct++) begin
      for (int s = 0; s < 12; s++) begin
        n = 12 * oct + s;
        if (n < NOTE_COUNT) begin
          f = 64'(SEMITONE_FREQ_Q24[s]) << (oct + 8);
          tbl[n] = 32'((f + 64'(SAMPLE_RATE_HZ / 2)) / 64'(SAMPLE_RATE_HZ));
        end
      end
    end
    return tbl;
  endfunction

  function automatic level_table_t build_level_table();
    level_table_t tbl;
    for (int v = 0; v < NOTE_COUNT; v++) begin
      tbl[v] = 16'((v * LEVEL_SCALE + LEVEL_ROUND) / LEVEL_DIV);
    end
    return tbl;
  endfunction

  // Quarter-wave odd polynomial, Q30 in, Q15 out
  function automatic logic [SAMPLE_W-1:0] sine_entry(int k);
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] t;
    logic [63:0] s;
    x  = 64'(k) << (30 - SINE_Q_W);
    x2 = (x * x) >> 30;
    t  = 64'd172271;
    t  = 64'd5026995 - ((x2 * t) >> 30);
    t  = 64'd85569306 - ((x2 * t) >> 30);
    t  = 64'd693598677 - ((x2 * t) >> 30);
    t  = 64'd1686629713 - ((x2 * t) >> 30);
    s  = (x * t) >> 30;
    s  = (s + 64'd16384) >> 15;
    if (s > 64'd32767) s = 64'd32767;
    return s[SAMPLE_W-1:0];
  endfunction

  function automatic sine_table_t build_sine_table();
    sine_table_t tbl;
    for (int k = 0; k < SINE_QUARTER; k++) begin
      tbl[k] = sine_entry(k);
    end
    return tbl;
  endfunction

  localparam step_table_t  STEP_TABLE  = build_step_table();
  localparam level_table_t LEVEL_TABLE = build_level_table();
  localparam sine_table_t  SINE_TABLE  = build_sine_table();

endpackage

// File: sv/multiwave_voice_oscillator.sv
// Note on, note off and note kill commands yield no output.
// A sample tick steps through wave lookup, level multiply and release multiply
// into the output register; the sample is presented when the release step emits it,
// and the next command is taken in the cycle after that, not while a tick is in progress.
// A stalled output holds the tick in its last step until the register frees.
// Synchronous reset silences the voice, clears phase, step, level and release, shape sine.
module multiwave_voice_oscillator import mvo_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [15:0]           s_tdata,   // note_number[6:0], note_velocity[13:7]
  input  logic [1:0]            s_tuser,   // cmd[1:0]
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [23:0]           m_tdata,   // sample_out[15:0], voice_active[16]
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready
);

  logic [1:0]          wave_shape;
  dp_cmd_t             dp_cmd;
  dp_status_t          status;
  logic [SAMPLE_W-1:0] sample_out;
  logic                voice_active;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      wave_shape <= WAVE_SINE;
    end else if (psel && penable && pwrite && pready && (paddr == ADDR_WAVE_SHAPE)) begin
      wave_shape <= pwdata[1:0];
    end
  end

  assign prdata = (paddr == ADDR_WAVE_SHAPE) ? {30'd0, wave_shape} : 32'd0;

  mvo_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .cmd      (cmd_t'(s_tuser)),
    .status   (status),
    .s_tready (s_tready),
    .dp_cmd   (dp_cmd)
  );

  mvo_datapath u_datapath (
    .clk           (clk),
    .rst           (rst),
    .dp_cmd        (dp_cmd),
    .status        (status),
    .note_number   (s_tdata[6:0]),
    .note_velocity (s_tdata[13:7]),
    .wave_shape    (wave_shape),
    .m_tready      (m_tready),
    .m_tvalid      (m_tvalid),
    .sample_out    (sample_out),
    .voice_active  (voice_active)
  );

  assign m_tdata = {7'd0, voice_active, sample_out};

endmodule

// File: sv/mvo_ctrl.sv
module mvo_ctrl import mvo_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  input  cmd_t       cmd,
  input  dp_status_t status,
  output logic       s_tready,
  output dp_cmd_t    dp_cmd
);

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    dp_cmd     = '0;
    s_tready   = 1'b0;
    unique case (state)
      ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          unique case (cmd)
            CMD_TICK:      state_next = ST_WAVE;
            CMD_NOTE_ON:   dp_cmd.note_on = 1'b1;
            CMD_NOTE_OFF:  dp_cmd.note_off = 1'b1;
            CMD_NOTE_KILL: dp_cmd.note_kill = 1'b1;
          endcase
        end
      end
      ST_WAVE: begin
        dp_cmd.wave_load = 1'b1;
        state_next       = ST_LEVEL;
      end
      ST_LEVEL: begin
        dp_cmd.level_load = 1'b1;
        state_next        = ST_RELEASE;
      end
      ST_RELEASE: begin
        // hold until the output register can take the sample
        if (status.out_free) begin
          dp_cmd.emit = 1'b1;
          state_next  = ST_IDLE;
        end
      end
    endcase
  end

endmodule

// File: sv/mvo_datapath.sv
module mvo_datapath import mvo_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  dp_cmd_t             dp_cmd,
  output dp_status_t          status,
  input  logic [NOTE_W-1:0]   note_number,
  input  logic [VEL_W-1:0]    note_velocity,
  input  logic [1:0]          wave_shape,
  input  logic                m_tready,
  output logic                m_tvalid,
  output logic [SAMPLE_W-1:0] sample_out,
  output logic                voice_active
);

  logic [PHASE_W-1:0]  phase_acc;
  logic [PHASE_W-1:0]  phase_step;
  logic [LEVEL_W-1:0]  voice_level;
  logic [RF_W-1:0]     release_factor;
  logic                releasing;
  logic                sounding;

  logic [SAMPLE_W-1:0] wave_val;
  logic [RF_W-1:0]     rf_dec;
  logic [SAMPLE_W-1:0] lvl_mag;
  logic                wave_neg;

  // wave generation
  logic [SINE_IDX_W-1:0] sin_idx;
  logic [1:0]            sin_quad;
  logic [SINE_Q_W-1:0]   sin_low;
  logic [SINE_Q_W-1:0]   sin_k;
  logic [SAMPLE_W-1:0]   sin_mag;
  logic [SAMPLE_W-1:0]   sin_val;
  logic [PHASE_W-1:0]    tri_q;
  logic [PHASE_W-1:0]    tri_d;
  logic signed [17:0]    tri_v;
  logic [SAMPLE_W-1:0]   tri_val;
  logic [SAMPLE_W-1:0]   wave_sel;

  // scaling
  logic [30:0]           dec_prod;
  logic [31:0]           dec_sum;
  logic [SAMPLE_W-1:0]   wave_mag;
  logic [31:0]           lvl_prod;
  logic [32:0]           lvl_sum;
  logic [31:0]           rel_prod;
  logic [31:0]           rel_sum;
  logic [SAMPLE_W-1:0]   fin_mag;
  logic [SAMPLE_W-1:0]   sample_res;
  logic                  rf_stop;
  logic                  active_res;

  assign sin_idx  = phase_acc[PHASE_W-1 -: SINE_IDX_W];
  assign sin_quad = sin_idx[SINE_IDX_W-1 -: 2];
  assign sin_low  = sin_idx[SINE_Q_W-1:0];
  assign sin_k    = sin_quad[0] ? (~sin_low + 1'b1) : sin_low;
  // falling quarter at its start is the peak itself
  assign sin_mag  = (sin_quad[0] && (sin_low == '0)) ? WAVE_MAX : SINE_TABLE[sin_k];
  assign sin_val  = sin_quad[1] ? (~sin_mag + 1'b1) : sin_mag;

  assign tri_q   = phase_acc + 32'h4000_0000;
  assign tri_d   = tri_q[31] ? (tri_q - 32'h8000_0000) : (32'h8000_0000 - tri_q);
  assign tri_v   = 18'sd32768 - $signed({1'b0, tri_d[31:15]});
  assign tri_val = (tri_v > 18'sd32767) ? WAVE_MAX : tri_v[SAMPLE_W-1:0];

  always_comb begin
    unique case (wave_t'(wave_shape))
      WAVE_SINE:     wave_sel = sin_val;
      WAVE_SQUARE:   wave_sel = phase_acc[31] ? WAVE_MIN : WAVE_MAX;
      WAVE_SAW:      wave_sel = {~phase_acc[31], phase_acc[30:16]};
      WAVE_TRIANGLE: wave_sel = tri_val;
    endcase
  end

  assign dec_prod = release_factor * RF_DECAY;
  assign dec_sum  = {1'b0, dec_prod} + 32'd16384;

  assign wave_mag = wave_val[SAMPLE_W-1] ? (~wave_val + 1'b1) : wave_val;
  assign lvl_prod = wave_mag * voice_level;
  assign lvl_sum  = {1'b0, lvl_prod} + 33'd32768;

  assign rel_prod   = lvl_mag * release_factor;
  assign rel_sum    = rel_prod + 32'd16384;
  assign fin_mag    = releasing ? rel_sum[30:15] : lvl_mag;
  assign sample_res = wave_neg ? (~fin_mag + 1'b1) : fin_mag;
  assign rf_stop    = rf_dec <= RF_STOP;
  assign active_res = sounding && !(releasing && rf_stop);

  assign status.out_free = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase_acc      <= '0;
      phase_step     <= '0;
      voice_level    <= '0;
      release_factor <= '0;
      releasing      <= 1'b0;
      sounding       <= 1'b0;
    end else begin
      if (dp_cmd.note_on) begin
        phase_step     <= STEP_TABLE[note_number];
        voice_level    <= LEVEL_TABLE[note_velocity];
        release_factor <= '0;
        releasing      <= 1'b0;
        sounding       <= 1'b1;
      end else if (dp_cmd.note_off) begin
        if (sounding && !releasing) begin
          release_factor <= RF_ONE;
          releasing      <= 1'b1;
        end
      end else if (dp_cmd.note_kill) begin
        sounding       <= 1'b0;
        releasing      <= 1'b0;
        release_factor <= '0;
        phase_step     <= '0;
      end else if (dp_cmd.wave_load) begin
        if (sounding) phase_acc <= phase_acc + phase_step;
      end else if (dp_cmd.emit && releasing) begin
        if (rf_stop) begin
          sounding       <= 1'b0;
          releasing      <= 1'b0;
          release_factor <= '0;
          phase_step     <= '0;
        end else begin
          release_factor <= rf_dec;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (dp_cmd.wave_load) begin
      // silent voice yields a zero sample
      wave_val <= sounding ? wave_sel : '0;
      rf_dec   <= dec_sum[30:15];
    end
    if (dp_cmd.level_load) begin
      lvl_mag  <= lvl_sum[31:16];
      wave_neg <= wave_val[SAMPLE_W-1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (dp_cmd.emit) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (dp_cmd.emit) begin
      sample_out   <= sample_res;
      voice_active <= active_res;
    end
  end

endmodule

// File: tb/multiwave_voice_oscillator_tb.sv
`timescale 1ns / 1ps

module multiwave_voice_oscillator_tb;
  import mvo_pkg::*;

  localparam int CYCLE_LIMIT  = 400000;
  localparam int PHASE_ITEMS  = 5;
  localparam int DRAIN_CYCLES = 8;

  typedef struct {
    logic [15:0] sample;
    logic        active;
  } voice_result_t;

  // Semitone frequencies of the lowest octave, Q24 Hz
  localparam logic [31:0] NOTE_FREQ_Q24 [12] = '{
    32'd137167145, 32'd145323527, 32'd153964914, 32'd163120145,
    32'd172819773, 32'd183096171, 32'd193983637, 32'd205518504,
    32'd217739270, 32'd230686720, 32'd244404066, 32'd258937088
  };

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [15:0]           s_tdata = '0;   // note_number[6:0], note_velocity[13:7]
  logic [1:0]            s_tuser = '0;   // cmd[1:0]
  logic                  m_tvalid;
  logic                  m_tready = 1'b1;
  logic [23:0]           m_tdata;        // sample_out[15:0], voice_active[16]
  logic                  psel = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite = 1'b0;
  logic [APB_ADDR_W-1:0] paddr = '0;
  logic [31:0]           pwdata = '0;
  logic [31:0]           prdata;
  logic                  pready;

  multiwave_voice_oscillator u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Voice state as the testbench tracks it
  wave_t       shape_reg;
  logic [31:0] phase_acc;
  logic [31:0] phase_step;
  logic [15:0] voice_level;
  logic [15:0] release_gain;
  logic        releasing;
  logic        sounding;

  voice_result_t sample_q[$];
  int fail_count = 0;
  int sent_count = 0;
  int cycle_count = 0;
  int stall_left = 0;
  int stall_roll;
  bit quiet = 1'b0;

  function automatic logic [31:0] note_step(logic [6:0] note);
    logic [63:0] f;
    f = 64'(NOTE_FREQ_Q24[note % 12]) << (note / 12 + 8);
    return 32'((f + 64'(SAMPLE_RATE_HZ / 2)) / 64'(SAMPLE_RATE_HZ));
  endfunction

  function automatic logic [15:0] velocity_level(logic [6:0] vel);
    return 16'((32'(vel) * 98304 + 635) / 1270);
  endfunction

  function automatic int sine_q15(logic [31:0] ph);
    logic [63:0] idx;
    logic [63:0] a;
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] t;
    logic [63:0] s;
    logic [1:0]  quad;
    idx  = (64'(ph) * 64'(SINE_TABLE_DEPTH)) >> 32;
    a    = (idx << 32) / 64'(SINE_TABLE_DEPTH);
    quad = a[31:30];
    x    = {34'd0, a[29:0]};
    if (quad[0]) x = 64'h4000_0000 - x;
    x2 = (x * x) >> 30;
    t  = 64'd172271;
    t  = 64'd5026995 - ((x2 * t) >> 30);
    t  = 64'd85569306 - ((x2 * t) >> 30);
    t  = 64'd693598677 - ((x2 * t) >> 30);
    t  = 64'd1686629713 - ((x2 * t) >> 30);
    s  = (x * t) >> 30;
    s  = (s + 64'd16384) >> 15;
    if (s > 64'd32767) s = 64'd32767;
    return quad[1] ? -int'(s) : int'(s);
  endfunction

  function automatic int shape_value(wave_t shape, logic [31:0] ph);
    logic [31:0] q;
    logic [31:0] d;
    int v;
    case (shape)
      WAVE_SQUARE: return ph[31] ? -32767 : 32767;
      WAVE_SAW: return int'({16'd0, ph[31:16]}) - 32768;
      WAVE_TRIANGLE: begin
        q = ph + 32'h4000_0000;
        d = q[31] ? q - 32'h8000_0000 : 32'h8000_0000 - q;
        v = 32768 - int'(d >> 15);
        return (v > 32767) ? 32767 : v;
      end
      default: return sine_q15(ph);
    endcase
  endfunction

  // Signed value times unsigned gain over 2^sh, rounded half away from zero
  function automatic int scale_round(int v, int unsigned g, int sh);
    logic [63:0] mag;
    mag = 64'(v < 0 ? -v : v) * 64'(g);
    mag = (mag + (64'd1 << (sh - 1))) >> sh;
    return v < 0 ? -int'(mag) : int'(mag);
  endfunction

  task automatic advance_voice(cmd_t c, logic [6:0] note, logic [6:0] vel);
    voice_result_t r;
    int smp;
    case (c)
      CMD_NOTE_ON: begin
        phase_step   = note_step(note);
        voice_level  = velocity_level(vel);
        release_gain = '0;
        releasing    = 1'b0;
        sounding     = 1'b1;
      end
      CMD_NOTE_OFF: begin
        if (sounding && !releasing) begin
          release_gain = 16'd32768;
          releasing    = 1'b1;
        end
      end
      CMD_NOTE_KILL: begin
        sounding     = 1'b0;
        releasing    = 1'b0;
        release_gain = '0;
        phase_step   = '0;
      end
      default: begin
        smp = 0;
        if (sounding) begin
          smp = scale_round(shape_value(shape_reg, phase_acc), voice_level, 16);
          phase_acc = phase_acc + phase_step;
          if (releasing) begin
            smp = scale_round(smp, release_gain, 15);
            release_gain = 16'((32'(release_gain) * 32440 + 16384) >> 15);
            if (release_gain <= 16'd163) begin
              sounding     = 1'b0;
              releasing    = 1'b0;
              release_gain = '0;
              phase_step   = '0;
            end
          end
        end
        r.sample = smp[15:0];
        r.active = sounding;
        sample_q.push_back(r);
      end
    endcase
  endtask

  function automatic int pick_gap();
    int r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(5, 30);
  endfunction

  task automatic send_item(cmd_t c, logic [6:0] note, logic [6:0] vel);
    int gap;
    gap = pick_gap();
    @(negedge clk);
    if (gap > 0) begin
      s_tvalid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid = 1'b1;
    s_tuser  = c;
    s_tdata  = {2'b00, vel, note};
    do @(posedge clk); while (!s_tready);
    advance_voice(c, note, vel);
    sent_count++;
  endtask

  task automatic send_tick();
    send_item(CMD_TICK, 7'($urandom), 7'($urandom));
  endtask

  // Drop valid and hold until every predicted sample has arrived
  task automatic wait_drain(int settle);
    @(negedge clk);
    s_tvalid = 1'b0;
    while (sample_q.size() != 0) @(posedge clk);
    repeat (settle) @(posedge clk);
  endtask

  task automatic write_shape(logic [31:0] value);
    @(negedge clk);
    psel    = 1'b1;
    pwrite  = 1'b1;
    paddr   = ADDR_WAVE_SHAPE;
    pwdata  = value;
    penable = 1'b0;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    shape_reg = wave_t'(value[1:0]);
    @(negedge clk);
    pwrite  = 1'b0;
    penable = 1'b0;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== {30'd0, shape_reg}) begin
      $display("%0t wave_shape read expected %0d got %0d", $time, shape_reg, prdata);
      fail_count++;
    end
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
  endtask

  always @(negedge clk) begin
    if (quiet || rst) begin
      m_tready = 1'b1;
    end else if (stall_left > 0) begin
      stall_left--;
      m_tready = 1'b0;
    end else begin
      stall_roll = $urandom_range(0, 99);
      if (stall_roll < 70) begin
        m_tready = 1'b1;
      end else if (stall_roll < 95) begin
        m_tready   = 1'b0;
        stall_left = $urandom_range(0, 2);
      end else begin
        m_tready   = 1'b0;
        stall_left = $urandom_range(8, 40);
      end
    end
  end

  always @(posedge clk) begin
    voice_result_t e;
    if (!rst && m_tvalid && m_tready) begin
      if (sample_q.size() == 0) begin
        $display("%0t unexpected transfer: expected none got sample %0d active %0b",
                 $time, $signed(m_tdata[15:0]), m_tdata[16]);
        fail_count++;
      end else begin
        e = sample_q.pop_front();
        if (m_tdata[15:0] !== e.sample) begin
          $display("%0t sample_out expected %0d got %0d", $time,
                   $signed(e.sample), $signed(m_tdata[15:0]));
          fail_count++;
        end
        if (m_tdata[16] !== e.active) begin
          $display("%0t voice_active expected %0b got %0b", $time, e.active, m_tdata[16]);
          fail_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("[multiwave_voice_oscillator] ERROR");
      $finish;
    end
  end

  task automatic test_commands();
    send_tick();
    send_item(CMD_NOTE_OFF, 7'd5, 7'd90);
    send_item(CMD_NOTE_KILL, 7'd127, 7'd127);
    send_tick();
    // highest note stays below half the sample rate
    send_item(CMD_NOTE_ON, 7'd127, 7'd127);
    repeat (2) send_tick();
    send_item(CMD_NOTE_ON, 7'd0, 7'd0);
    repeat (2) send_tick();
    send_item(CMD_NOTE_ON, 7'd69, 7'd1);
    send_tick();
    send_item(CMD_NOTE_OFF, 7'd0, 7'd0);
    repeat (2) send_tick();
    send_item(CMD_NOTE_OFF, 7'd0, 7'd0);
    send_tick();
    send_item(CMD_NOTE_ON, 7'd60, 7'd100);
    repeat (2) send_tick();
    send_item(CMD_NOTE_KILL, 7'd0, 7'd0);
    send_tick();
    send_item(CMD_NOTE_ON, 7'd64, 7'd127);
    send_tick();
  endtask

  task automatic test_shapes();
    for (int s = 0; s < 4; s++) begin
      wait_drain(DRAIN_CYCLES);
      write_shape({30'($urandom), 2'(s)});
      send_item(CMD_NOTE_ON, 7'($urandom_range(40, 100)), 7'd127);
      repeat (3) send_tick();
    end
  endtask

  task automatic test_release_tail();
    wait_drain(DRAIN_CYCLES);
    write_shape(32'($urandom_range(0, 3)));
    send_item(CMD_NOTE_ON, 7'($urandom_range(60, 90)), 7'd127);
    repeat (4) send_tick();
    send_item(CMD_NOTE_OFF, 7'd0, 7'd0);
    while (sounding) send_tick();
    repeat (2) send_tick();
  endtask

  task automatic test_random();
    int stop_at;
    int r;
    for (int ph = 0; ph < 6; ph++) begin
      wait_drain(DRAIN_CYCLES);
      write_shape(ph < 4 ? {30'($urandom), 2'(ph)} : $urandom);
      quiet   = (ph == 4);
      stop_at = sent_count + PHASE_ITEMS;
      while (sent_count < stop_at) begin
        r = $urandom_range(0, 99);
        if (r < 85) begin
          send_item(CMD_NOTE_ON,
                    ($urandom_range(0, 3) == 0) ? 7'($urandom_range(0, 11)) : 7'($urandom),
                    7'($urandom));
          repeat ($urandom_range(1, 12)) send_tick();
          r = $urandom_range(0, 99);
          if (r < 45) begin
            send_item(CMD_NOTE_OFF, 7'($urandom), 7'($urandom));
            repeat ($urandom_range(0, 15)) send_tick();
          end else if (r < 70) begin
            send_item(CMD_NOTE_KILL, 7'($urandom), 7'($urandom));
            repeat ($urandom_range(0, 2)) send_tick();
          end
        end else begin
          repeat ($urandom_range(1, 4))
            send_item(cmd_t'($urandom_range(0, 3)), 7'($urandom), 7'($urandom));
        end
        if ($urandom_range(0, 19) == 0) wait_drain(0);
      end
    end
    quiet = 1'b0;
  endtask

  initial begin
    shape_reg    = WAVE_SINE;
    phase_acc    = '0;
    phase_step   = '0;
    voice_level  = '0;
    release_gain = '0;
    releasing    = 1'b0;
    sounding     = 1'b0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_commands();
    test_shapes();
    test_release_tail();
    test_random();

    wait_drain(10);
    if (fail_count == 0) begin
      $display("[multiwave_voice_oscillator] OK");
    end else begin
      $display("[multiwave_voice_oscillator] ERROR");
    end
    $finish;
  end

endmodule
